// ===== src/mfac_pkg.sv =====
`timescale 1ns / 1ps

package mfac_pkg;

  // Input item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  localparam logic [7:0]  START_MARK     = 8'hF0;
  localparam logic [7:0]  END_MARK       = 8'h55;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd9;

  // Results caused by one item, at most
  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [CNT_W-1:0] mfac_cnt_t;

  localparam mfac_cnt_t HDR_RESULTS    = mfac_cnt_t'(6);
  localparam mfac_cnt_t FOOTER_RESULTS = mfac_cnt_t'(3);
  localparam mfac_cnt_t ONE_RESULT     = mfac_cnt_t'(1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  msg_class;
    logic [7:0]  seq_num;
    logic [7:0]  msg_type;
    logic [15:0] body_length;
    logic [7:0]  data_byte;
  } mfac_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } mfac_out_t;

endpackage

// ===== src/message_framer_additive_checksum.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     in_data_i  (mfac_pkg::mfac_in_t)
// out      output     out_valid_o / out_ready_i   out_data_o (mfac_pkg::mfac_out_t)
//
// An accepted item is expanded into a short byte queue (up to 9 bytes),
// which drains into the output register at one byte per cycle unless the output stalls.
// The next item is taken in the cycle the last queued byte moves to the output register.
// Reset clears the frame state, the queue count and the output valid.
// A stalled output holds the queue; an item that gives no result is still taken.

module message_framer_additive_checksum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfac_pkg::mfac_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfac_pkg::mfac_out_t out_data_o
);

  // Frame state
  logic        frame_open_q, frame_open_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [15:0] running_sum_q, running_sum_d;

  // Byte queue: slot 0 goes out next
  logic [7:0]          work_q [mfac_pkg::MAX_RESULTS];
  logic [7:0]          work_d [mfac_pkg::MAX_RESULTS];
  mfac_pkg::mfac_cnt_t cnt_q, cnt_d;
  logic                footer_q, footer_d;

  logic                out_valid_q, out_valid_d;
  mfac_pkg::mfac_out_t out_q, out_d;

  logic load_out, emit, accept;

  logic [15:0] total;
  logic [15:0] hdr_sum;
  logic [15:0] body_sum;
  logic [15:0] left_dec;

  assign load_out   = !out_valid_q || out_ready_i;
  assign emit       = load_out && (cnt_q != '0);
  assign in_ready_o = (cnt_q == '0) || (emit && (cnt_q == mfac_pkg::ONE_RESULT));
  assign accept     = in_valid_i && in_ready_o;

  assign total    = in_data_i.body_length + mfac_pkg::FRAME_OVERHEAD;
  assign hdr_sum  = {8'h00, total[7:0]} + {8'h00, total[15:8]} +
                    {8'h00, in_data_i.msg_class} + {8'h00, in_data_i.seq_num} +
                    {8'h00, in_data_i.msg_type};
  assign body_sum = running_sum_q + {8'h00, in_data_i.data_byte};
  assign left_dec = bytes_left_q - 16'd1;

  always_comb begin
    frame_open_d  = frame_open_q;
    bytes_left_d  = bytes_left_q;
    running_sum_d = running_sum_q;
    footer_d      = footer_q;
    cnt_d         = cnt_q;
    for (int i = 0; i < mfac_pkg::MAX_RESULTS; i++) begin
      work_d[i] = work_q[i];
    end

    // Advance the queue by one byte
    if (emit) begin
      for (int i = 0; i < mfac_pkg::MAX_RESULTS - 1; i++) begin
        work_d[i] = work_q[i+1];
      end
      work_d[mfac_pkg::MAX_RESULTS-1] = '0;
      cnt_d = cnt_q - mfac_pkg::ONE_RESULT;
    end

    if (accept) begin
      cnt_d    = '0;
      footer_d = 1'b0;
      if (in_data_i.kind == mfac_pkg::KIND_HEADER) begin
        work_d[0] = mfac_pkg::START_MARK;
        work_d[1] = total[7:0];
        work_d[2] = total[15:8];
        work_d[3] = in_data_i.msg_class;
        work_d[4] = in_data_i.seq_num;
        work_d[5] = in_data_i.msg_type;
        work_d[6] = hdr_sum[7:0];
        work_d[7] = hdr_sum[15:8];
        work_d[8] = mfac_pkg::END_MARK;
        if (in_data_i.body_length == 16'd0) begin
          // Empty body: close the frame right away
          cnt_d         = mfac_pkg::HDR_RESULTS + mfac_pkg::FOOTER_RESULTS;
          footer_d      = 1'b1;
          frame_open_d  = 1'b0;
          bytes_left_d  = '0;
          running_sum_d = '0;
        end else begin
          cnt_d         = mfac_pkg::HDR_RESULTS;
          frame_open_d  = 1'b1;
          bytes_left_d  = in_data_i.body_length;
          running_sum_d = hdr_sum;
        end
      end else if (frame_open_q) begin
        work_d[0] = in_data_i.data_byte;
        work_d[1] = body_sum[7:0];
        work_d[2] = body_sum[15:8];
        work_d[3] = mfac_pkg::END_MARK;
        if (left_dec == 16'd0) begin
          cnt_d         = mfac_pkg::ONE_RESULT + mfac_pkg::FOOTER_RESULTS;
          footer_d      = 1'b1;
          frame_open_d  = 1'b0;
          bytes_left_d  = '0;
          running_sum_d = '0;
        end else begin
          cnt_d         = mfac_pkg::ONE_RESULT;
          bytes_left_d  = left_dec;
          running_sum_d = body_sum;
        end
      end
      // Body byte outside a frame: drop it
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d     = (cnt_q != '0);
      out_d.out_byte  = work_q[0];
      out_d.run_last  = (cnt_q == mfac_pkg::ONE_RESULT);
      out_d.frame_end = footer_q && (cnt_q == mfac_pkg::ONE_RESULT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q  <= 1'b0;
      bytes_left_q  <= '0;
      running_sum_q <= '0;
      cnt_q         <= '0;
      footer_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      frame_open_q  <= frame_open_d;
      bytes_left_q  <= bytes_left_d;
      running_sum_q <= running_sum_d;
      cnt_q         <= cnt_d;
      footer_q      <= footer_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < mfac_pkg::MAX_RESULTS; i++) begin
      work_q[i] <= work_d[i];
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic mfac_pkg::mfac_cnt_t mfac_cnt_max();
    return mfac_pkg::mfac_cnt_t'(mfac_pkg::MAX_RESULTS);
  endfunction

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mfac_cnt_max())
    else $error("queue count above the result limit");

  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_open_q |-> (bytes_left_q == '0) && (running_sum_q == '0))
    else $error("closed frame left stale state");

  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.run_last && (out_q.out_byte == mfac_pkg::END_MARK))
    else $error("frame end without end byte or run end");

  a_hdr_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.kind == mfac_pkg::KIND_HEADER) |=>
      (work_q[0] == mfac_pkg::START_MARK) &&
      ((cnt_q == mfac_pkg::HDR_RESULTS) ||
       (cnt_q == mfac_pkg::HDR_RESULTS + mfac_pkg::FOOTER_RESULTS)))
    else $error("header did not load a start byte");

  a_open_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q |-> (bytes_left_q != '0))
    else $error("open frame expects no body bytes");

endmodule

// ===== bench/message_framer_additive_checksum_tb.sv =====
`timescale 1ns / 1ps

module message_framer_additive_checksum_tb;

  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned DRAIN_EVERY  = 60;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 50;

  typedef struct {
    mfac_pkg::mfac_in_t payload;
    bit                 drain_first;
  } tx_item_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  mfac_pkg::mfac_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mfac_pkg::mfac_out_t out_data;

  tx_item_t            tx_items[$];
  mfac_pkg::mfac_out_t framed_bytes_q[$];

  // Predicted framer state
  logic        f_open = 1'b0;
  logic [15:0] f_left = '0;
  logic [15:0] f_sum  = '0;

  int n_loaded    = 0;
  int n_accepted  = 0;
  int n_headers   = 0;
  int n_body      = 0;
  int n_ignored   = 0;
  int n_frames    = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int in_gap      = 0;
  int out_gap     = 0;
  int idle_cycles = 0;

  message_framer_additive_checksum i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_header(logic [7:0] cls, logic [7:0] seq, logic [7:0] typ,
                                     logic [15:0] len, bit drain = 1'b0);
    tx_item_t t;
    t.payload.kind        = mfac_pkg::KIND_HEADER;
    t.payload.msg_class   = cls;
    t.payload.seq_num     = seq;
    t.payload.msg_type    = typ;
    t.payload.body_length = len;
    t.payload.data_byte   = 8'($urandom);
    t.drain_first         = drain;
    tx_items.push_back(t);
    n_loaded++;
  endfunction

  // Header fields of a body item are don't-care: fill them with noise
  function automatic void add_body(logic [7:0] b);
    tx_item_t t;
    t.payload.kind        = mfac_pkg::KIND_BODY;
    t.payload.msg_class   = 8'($urandom);
    t.payload.seq_num     = 8'($urandom);
    t.payload.msg_type    = 8'($urandom);
    t.payload.body_length = 16'($urandom);
    t.payload.data_byte   = b;
    t.drain_first         = 1'b0;
    tx_items.push_back(t);
    n_loaded++;
  endfunction

  function automatic void frame_predict(mfac_pkg::mfac_in_t it);
    logic [7:0]          bytes[$];
    logic [15:0]         total;
    logic                closing;
    mfac_pkg::mfac_out_t r;
    closing = 1'b0;
    if (it.kind == mfac_pkg::KIND_HEADER) begin
      n_headers++;
      total = it.body_length + mfac_pkg::FRAME_OVERHEAD;
      bytes = '{mfac_pkg::START_MARK, total[7:0], total[15:8],
                it.msg_class, it.seq_num, it.msg_type};
      // A new header drops whatever frame was open
      f_sum = '0;
      for (int i = 1; i < bytes.size(); i++) f_sum += bytes[i];
      f_left  = it.body_length;
      f_open  = 1'b1;
      closing = (it.body_length == 16'd0);
    end else if (!f_open) begin
      n_ignored++;
      return;
    end else begin
      n_body++;
      bytes.push_back(it.data_byte);
      f_sum += it.data_byte;
      f_left--;
      closing = (f_left == 16'd0);
    end
    if (closing) begin
      bytes.push_back(f_sum[7:0]);
      bytes.push_back(f_sum[15:8]);
      bytes.push_back(mfac_pkg::END_MARK);
      f_open = 1'b0;
      f_left = '0;
      f_sum  = '0;
      n_frames++;
    end
    foreach (bytes[i]) begin
      r.out_byte  = bytes[i];
      r.run_last  = (i == bytes.size() - 1);
      r.frame_end = closing && (i == bytes.size() - 1);
      framed_bytes_q.push_back(r);
    end
  endfunction

  function automatic void compare_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // Input driver
  always @(posedge clk) begin
    logic               next_valid;
    logic               load;
    mfac_pkg::mfac_in_t next_data;
    next_valid = in_valid;
    load       = 1'b0;
    next_data  = in_data;
    if (in_valid && in_ready) begin
      frame_predict(in_data);
      n_accepted++;
      next_valid = 1'b0;
    end
    if (!next_valid && rst_n) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (tx_items.size() > 0 &&
                   !(tx_items[0].drain_first && framed_bytes_q.size() != 0)) begin
        if (tx_items.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 5);
        end else begin
          next_data  = tx_items.pop_front().payload;
          next_valid = 1'b1;
          load       = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
    if (load) in_data <= next_data;
  end

  // Output monitor and stall generator
  always @(posedge clk) begin
    mfac_pkg::mfac_out_t want;
    logic                next_ready;
    if (out_valid && out_ready) begin
      n_results++;
      if (framed_bytes_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: output byte %h with none expected, expected nothing, actual %h",
                   $time, out_data.out_byte, out_data);
      end else begin
        want = framed_bytes_q.pop_front();
        compare_field("out_byte", want.out_byte, out_data.out_byte);
        compare_field("run_last", 8'(want.run_last), 8'(out_data.run_last));
        compare_field("frame_end", 8'(want.frame_end), 8'(out_data.frame_end));
      end
    end
    if (!rst_n) begin
      next_ready = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      next_ready = 1'b0;
    end else if (tx_items.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
      out_gap    = $urandom_range(0, 5);
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    out_ready <= next_ready;
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d bytes outstanding",
               $time, idle_cycles, framed_bytes_q.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n_gen;
    int sel;
    int len;
    int last_drain;
    n_gen      = 0;
    last_drain = 0;

    // Directed frames: field extremes, stray bytes, abandon, length wrap
    add_body(8'hA5);
    add_header(8'hFF, 8'hFF, 8'hFF, 16'd0);
    add_header(8'h00, 8'h00, 8'h00, 16'd0);
    add_header(8'h12, 8'h34, 8'h56, 16'd2);
    add_body(8'hFF);
    add_body(8'h00);
    add_header(8'h01, 8'h02, 8'h03, 16'd3);
    add_body(8'h80);
    add_header(8'hFF, 8'h00, 8'hFF, 16'd1);
    add_body(8'h7F);
    add_body(8'h3C);
    add_header(8'hA0, 8'hA1, 8'hA2, 16'd65526);
    add_body(8'hFF);
    add_body(8'h01);
    add_header(8'h5A, 8'hA5, 8'hC3, 16'hFFFF);
    add_body(8'h42);
    add_header(8'h00, 8'hFF, 8'h00, 16'd65527);
    add_header(8'h77, 8'h88, 8'h99, 16'd1, 1'b1);
    add_body(8'hFE);
    add_header(8'hC0, 8'h3F, 8'h81, 16'h8000);
    add_header(8'h0F, 8'hF0, 8'h55, 16'd0);

    // Mostly complete frames, some truncated by a new header, some stray bytes
    while (n_gen < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 15);
      if (sel < 11) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        add_header(8'($urandom), 8'($urandom), 8'($urandom), 16'(len),
                   (n_gen - last_drain) >= DRAIN_EVERY);
        if ((n_gen - last_drain) >= DRAIN_EVERY) last_drain = n_gen;
        for (int k = 0; k < len; k++) add_body(8'($urandom));
        n_gen += len + 1;
      end else if (sel < 14) begin
        len = $urandom_range(0, 4);
        add_header(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(0, 65535)));
        for (int k = 0; k < len; k++) add_body(8'($urandom));
        n_gen += len + 1;
      end else begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) add_body(8'($urandom));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_loaded) @(posedge clk);
    while (framed_bytes_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (framed_bytes_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected bytes never arrived", $time, framed_bytes_q.size());
    end
    $display("Sent %0d items: %0d headers, %0d body bytes, %0d stray bytes dropped",
             n_accepted, n_headers, n_body, n_ignored);
    $display("Checked %0d output bytes over %0d closed frames, %0d mismatches",
             n_results, n_frames, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mfac_pkg.sv
src/message_framer_additive_checksum.sv
bench/message_framer_additive_checksum_tb.sv
